// ===== sv/buffer_pool_ratio_fit_cache_top_macros.svh =====
// assertion macros shared by the buffer pool cache rtl
// needs a clock named clk and a reset named rst in the including module
`ifndef BUFFER_POOL_RATIO_FIT_CACHE_TOP_MACROS_SVH
`define BUFFER_POOL_RATIO_FIT_CACHE_TOP_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// next-cycle implication
`define BPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

// ===== sv/bpc_pkg.sv =====
// shared types, codes and arithmetic for the buffer pool cache
// no dependencies
package bpc_pkg;

  localparam int TBL_DEPTH  = 16;
  localparam int FREE_DEPTH = TBL_DEPTH;
  localparam int USED_DEPTH = TBL_DEPTH;
  localparam int SIZE_W     = 32;
  localparam int HANDLE_W   = 48;
  localparam int IDX_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TBL_DEPTH + 1);
  localparam int RATIO_W    = 9;
  localparam int THR_W      = 5;
  localparam int PROD_W     = SIZE_W + RATIO_W;

  localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(256);
  localparam logic [RATIO_W-1:0] RATIO_RST  = '0;
  localparam logic [THR_W-1:0]   THR_RST    = THR_W'(10);

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_BIND    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [2:0] STS_REUSED    = 3'd0;
  localparam logic [2:0] STS_NEED      = 3'd1;
  localparam logic [2:0] STS_BOUND     = 3'd2;
  localparam logic [2:0] STS_POOLED    = 3'd3;
  localparam logic [2:0] STS_WILD      = 3'd4;
  localparam logic [2:0] STS_POOL_FULL = 3'd5;
  localparam logic [2:0] STS_USED_FULL = 3'd6;

  localparam logic CFG_RATIO  = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic                append;
    logic [SIZE_W-1:0]   app_size;
    logic [HANDLE_W-1:0] app_handle;
    logic                remove;
    logic [IDX_W-1:0]    rm_idx;
  } tbl_cmd_t;

  // floor(s * r / 256), exact
  function automatic logic [PROD_W-1:0] scaled_size(input logic [SIZE_W-1:0] s,
                                                    input logic [RATIO_W-1:0] r);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(r);
    return p >> 8;
  endfunction

endpackage

// ===== sv/bpc_cell.sv =====
// one table entry: holds a size and a handle, loads a new entry or its neighbor's
// depends on bpc_pkg
module bpc_cell import bpc_pkg::*; (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [SIZE_W-1:0]   app_size,
  input  logic [HANDLE_W-1:0] app_handle,
  input  logic [SIZE_W-1:0]   nbr_size,
  input  logic [HANDLE_W-1:0] nbr_handle,
  output logic [SIZE_W-1:0]   size,
  output logic [HANDLE_W-1:0] handle
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      size   <= app_size;
      handle <= app_handle;
    end else if (ctl.shift) begin
      size   <= nbr_size;
      handle <= nbr_handle;
    end
  end

endmodule

// ===== sv/bpc_table.sv =====
// ordered table as a row of cells with a fill count; append at tail, remove with close-up
// depends on bpc_pkg, bpc_cell and the macro header
`include "buffer_pool_ratio_fit_cache_top_macros.svh"
module bpc_table import bpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  tbl_cmd_t            cmd,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [SIZE_W-1:0]   rd_size,
  output logic [HANDLE_W-1:0] rd_handle,
  output logic [CNT_W-1:0]    count
);

  logic [SIZE_W-1:0]   sizes   [TBL_DEPTH];
  logic [HANDLE_W-1:0] handles [TBL_DEPTH];
  logic [CNT_W-1:0]    count_next;

  for (genvar k = 0; k < TBL_DEPTH; k++) begin : g_cell
    cell_ctl_t           ctl;
    logic [SIZE_W-1:0]   nsz;
    logic [HANDLE_W-1:0] nhd;
    assign ctl.load  = cmd.append && (count == CNT_W'(k));
    assign ctl.shift = cmd.remove && (CNT_W'(k) >= CNT_W'(cmd.rm_idx));
    if (k == TBL_DEPTH - 1) begin : g_last
      assign nsz = sizes[k];
      assign nhd = handles[k];
    end else begin : g_mid
      assign nsz = sizes[k+1];
      assign nhd = handles[k+1];
    end
    bpc_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .app_size   (cmd.app_size),
      .app_handle (cmd.app_handle),
      .nbr_size   (nsz),
      .nbr_handle (nhd),
      .size       (sizes[k]),
      .handle     (handles[k])
    );
  end

  assign rd_size   = sizes[rd_idx];
  assign rd_handle = handles[rd_idx];

  always_comb begin
    count_next = count;
    if (cmd.append) count_next = count_next + CNT_W'(1);
    if (cmd.remove) count_next = count_next - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  `BPC_ASSERT_NOW(a_no_both, cmd.append, !cmd.remove)
  `BPC_ASSERT_NOW(a_app_room, cmd.append, count < CNT_W'(TBL_DEPTH))
  `BPC_ASSERT_NOW(a_rm_valid, cmd.remove, CNT_W'(cmd.rm_idx) < count)

endmodule

// ===== sv/buffer_pool_ratio_fit_cache_top.sv =====
// top level of the buffer pool cache: control sequencer, registers and two cell tables
// depends on bpc_pkg, bpc_table, bpc_cell and the macro header
//
//  channel | dir | beat fields (low bit up)
//  s_*     | in  | action, req_size, block_handle
//  m_*     | out | status, out_handle, out_size, evict_valid, evict_handle
//  cfg_*   | in  | index 0 compare_ratio, index 1 drop_threshold
//
// an allocate scans the free table and a release the in-use table, one entry per cycle;
// a scan with no match stops at the table's end; an allocate with a full in-use table skips it
// a scanned item passes from the scan state to the final state and from there to the output
// register; the next beat is taken once the sequencer is back in its idle state
// a bind goes straight to the final state and from there to the output register;
// an action of 3 is dropped in its accept cycle
// rst is synchronous, clears counts, sequencer, output valid, resets config; no clearing pass
// a result waits in the output register; the next beat is taken while it waits, and
// the sequencer holds in its final state until the output register is free
`include "buffer_pool_ratio_fit_cache_top_macros.svh"
module buffer_pool_ratio_fit_cache_top import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [87:0]        s_tdata,   // action[1:0], req_size[33:2], block_handle[81:34]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [135:0]       m_tdata,   // status, out_handle, out_size, evict_valid, evict_handle
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [RATIO_W-1:0] cfg_data
);

  // configuration
  logic [RATIO_W-1:0] compare_ratio;
  logic [THR_W-1:0]   drop_threshold;
  logic [RATIO_W-1:0] ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_ratio  <= RATIO_RST;
      drop_threshold <= THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATIO:  compare_ratio  <= cfg_data;
        CFG_THRESH: drop_threshold <= cfg_data[THR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign ratio = (compare_ratio > RATIO_ONE) ? RATIO_ONE : compare_ratio;

  // sequencer registers
  state_t              state, state_next;
  logic [1:0]          act, act_next;
  logic [SIZE_W-1:0]   rsize, rsize_next;
  logic [HANDLE_W-1:0] rhandle, rhandle_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic                hit, hit_next;
  logic [IDX_W-1:0]    sel_idx, sel_idx_next;
  logic [SIZE_W-1:0]   sel_size, sel_size_next;
  logic [HANDLE_W-1:0] sel_handle, sel_handle_next;
  logic [IDX_W-1:0]    min_idx, min_idx_next, max_idx, max_idx_next;
  logic [SIZE_W-1:0]   min_size, min_size_next, max_size, max_size_next;
  logic [HANDLE_W-1:0] min_handle, min_handle_next, max_handle, max_handle_next;

  // output register
  logic                o_valid, o_valid_next;
  logic [2:0]          o_status, o_status_next;
  logic [HANDLE_W-1:0] o_handle, o_handle_next;
  logic [SIZE_W-1:0]   o_size, o_size_next;
  logic                o_ev, o_ev_next;
  logic [HANDLE_W-1:0] o_eh, o_eh_next;

  // tables
  tbl_cmd_t            free_cmd, used_cmd;
  logic [SIZE_W-1:0]   free_rd_size, used_rd_size;
  logic [HANDLE_W-1:0] free_rd_handle, used_rd_handle;
  logic [CNT_W-1:0]    free_count, used_count;
  logic [IDX_W-1:0]    rd_idx;

  assign rd_idx = idx[IDX_W-1:0];

  bpc_table u_free (
    .clk (clk), .rst (rst), .cmd (free_cmd), .rd_idx (rd_idx),
    .rd_size (free_rd_size), .rd_handle (free_rd_handle), .count (free_count)
  );

  bpc_table u_used (
    .clk (clk), .rst (rst), .cmd (used_cmd), .rd_idx (rd_idx),
    .rd_size (used_rd_size), .rd_handle (used_rd_handle), .count (used_count)
  );

  logic s_fire, out_free, used_full, free_full, fit, first, evict_ok;
  logic [CNT_W-1:0] limit;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !o_valid || m_tready;
  assign used_full = (used_count >= CNT_W'(USED_DEPTH));
  assign free_full = (free_count >= CNT_W'(FREE_DEPTH));
  assign limit     = (act == ACT_ALLOC) ? free_count : used_count;
  assign first     = (idx == '0);
  assign fit       = (free_rd_size >= rsize) &&
                     (scaled_size(free_rd_size, ratio) <= PROD_W'(rsize));
  assign evict_ok  = (free_count != '0) && (CNT_W'(free_count) >= CNT_W'(drop_threshold));

  always_comb begin
    state_next      = state;
    act_next        = act;
    rsize_next      = rsize;
    rhandle_next    = rhandle;
    idx_next        = idx;
    hit_next        = hit;
    sel_idx_next    = sel_idx;
    sel_size_next   = sel_size;
    sel_handle_next = sel_handle;
    min_idx_next    = min_idx;
    max_idx_next    = max_idx;
    min_size_next   = min_size;
    max_size_next   = max_size;
    min_handle_next = min_handle;
    max_handle_next = max_handle;
    o_valid_next    = o_valid && !m_tready;
    o_status_next   = o_status;
    o_handle_next   = o_handle;
    o_size_next     = o_size;
    o_ev_next       = o_ev;
    o_eh_next       = o_eh;
    free_cmd        = '0;
    used_cmd        = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          act_next     = s_tdata[1:0];
          rsize_next   = s_tdata[33:2];
          rhandle_next = s_tdata[81:34];
          idx_next     = '0;
          hit_next     = 1'b0;
          priority case (s_tdata[1:0])
            ACT_NONE: state_next = ST_IDLE;
            ACT_BIND: state_next = ST_FIN;
            default:  state_next = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if ((act == ACT_ALLOC && used_full) || idx == limit) begin
          state_next = ST_FIN;
        end else if (act == ACT_ALLOC) begin
          if (fit) begin
            hit_next        = 1'b1;
            sel_idx_next    = rd_idx;
            sel_size_next   = free_rd_size;
            sel_handle_next = free_rd_handle;
            state_next      = ST_FIN;
          end else begin
            // first smallest and first largest seen so far
            if (first || free_rd_size < min_size) begin
              min_idx_next    = rd_idx;
              min_size_next   = free_rd_size;
              min_handle_next = free_rd_handle;
            end
            if (first || free_rd_size > max_size) begin
              max_idx_next    = rd_idx;
              max_size_next   = free_rd_size;
              max_handle_next = free_rd_handle;
            end
            idx_next = idx + CNT_W'(1);
          end
        end else begin
          if (used_rd_handle == rhandle) begin
            hit_next      = 1'b1;
            sel_idx_next  = rd_idx;
            sel_size_next = used_rd_size;
            state_next    = ST_FIN;
          end else begin
            idx_next = idx + CNT_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next    = ST_IDLE;
          o_valid_next  = 1'b1;
          o_handle_next = '0;
          o_size_next   = '0;
          o_ev_next     = 1'b0;
          o_eh_next     = '0;
          priority case (act)
            ACT_ALLOC: begin
              if (used_full) begin
                o_status_next = STS_USED_FULL;
              end else if (hit) begin
                o_status_next       = STS_REUSED;
                o_handle_next       = sel_handle;
                o_size_next         = sel_size;
                free_cmd.remove     = 1'b1;
                free_cmd.rm_idx     = sel_idx;
                used_cmd.append     = 1'b1;
                used_cmd.app_size   = sel_size;
                used_cmd.app_handle = sel_handle;
              end else begin
                o_status_next = STS_NEED;
                if (evict_ok && max_size < rsize) begin
                  o_ev_next       = 1'b1;
                  o_eh_next       = min_handle;
                  free_cmd.remove = 1'b1;
                  free_cmd.rm_idx = min_idx;
                end else if (evict_ok && min_size > rsize) begin
                  o_ev_next       = 1'b1;
                  o_eh_next       = max_handle;
                  free_cmd.remove = 1'b1;
                  free_cmd.rm_idx = max_idx;
                end
              end
            end
            ACT_BIND: begin
              if (used_full) begin
                o_status_next = STS_USED_FULL;
                o_ev_next     = 1'b1;
                o_eh_next     = rhandle;
              end else begin
                o_status_next       = STS_BOUND;
                used_cmd.append     = 1'b1;
                used_cmd.app_size   = rsize;
                used_cmd.app_handle = rhandle;
              end
            end
            default: begin
              if (!hit) begin
                o_status_next = STS_WILD;
                o_ev_next     = 1'b1;
                o_eh_next     = rhandle;
              end else begin
                used_cmd.remove = 1'b1;
                used_cmd.rm_idx = sel_idx;
                if (free_full) begin
                  o_status_next = STS_POOL_FULL;
                  o_ev_next     = 1'b1;
                  o_eh_next     = rhandle;
                end else begin
                  o_status_next       = STS_POOLED;
                  free_cmd.append     = 1'b1;
                  free_cmd.app_size   = sel_size;
                  free_cmd.app_handle = rhandle;
                end
              end
            end
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    rsize      <= rsize_next;
    rhandle    <= rhandle_next;
    idx        <= idx_next;
    hit        <= hit_next;
    sel_idx    <= sel_idx_next;
    sel_size   <= sel_size_next;
    sel_handle <= sel_handle_next;
    min_idx    <= min_idx_next;
    max_idx    <= max_idx_next;
    min_size   <= min_size_next;
    max_size   <= max_size_next;
    min_handle <= min_handle_next;
    max_handle <= max_handle_next;
    o_status   <= o_status_next;
    o_handle   <= o_handle_next;
    o_size     <= o_size_next;
    o_ev       <= o_ev_next;
    o_eh       <= o_eh_next;
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {4'b0, o_eh, o_ev, o_size, o_handle, o_status};

  `BPC_ASSERT_NXT(a_drop_none, s_fire && s_tdata[1:0] == ACT_NONE, state == ST_IDLE)
  `BPC_ASSERT_NXT(a_take_item, s_fire && s_tdata[1:0] != ACT_NONE, state != ST_IDLE)
  `BPC_ASSERT_NXT(a_fin_out, state == ST_FIN && out_free, m_tvalid)
  `BPC_ASSERT_NOW(a_scan_bound, state == ST_SCAN, idx <= limit)

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the buffer pool ratio-fit cache
// depends on bpc_pkg and buffer_pool_ratio_fit_cache_top; keeps its own pool model
`timescale 1ns / 100ps
module tb;
  import bpc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 24;

  // packed low field last, so status sits in the low bits as on m_tdata
  typedef struct packed {
    logic [HANDLE_W-1:0] evict_handle;
    logic                evict_valid;
    logic [SIZE_W-1:0]   out_size;
    logic [HANDLE_W-1:0] out_handle;
    logic [2:0]          status;
  } pool_reply_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [87:0]        s_tdata;   // action, req_size, block_handle
  logic               m_tvalid;
  logic               m_tready;
  logic [135:0]       m_tdata;   // status, out_handle, out_size, evict_valid, evict_handle
  logic               cfg_we;
  logic               cfg_index;
  logic [RATIO_W-1:0] cfg_data;

  buffer_pool_ratio_fit_cache_top uut (.*);

  // mirror of the block's two tables and its registers
  logic [SIZE_W-1:0]   free_sz [TBL_DEPTH];
  logic [HANDLE_W-1:0] free_hd [TBL_DEPTH];
  int                  free_cnt;
  logic [SIZE_W-1:0]   used_sz [TBL_DEPTH];
  logic [HANDLE_W-1:0] used_hd [TBL_DEPTH];
  int                  used_cnt;
  logic [RATIO_W-1:0]  fit_ratio;
  logic [THR_W-1:0]    drop_thr;

  pool_reply_t pending_replies[$];
  int          errors;
  int          cycles;
  bit          no_idle;      // sender and receiver run flat out
  int          hold_cycles;  // one-shot long receiver stall

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void free_drop(int idx);
    for (int k = idx; k + 1 < free_cnt; k++) begin
      free_sz[k] = free_sz[k+1];
      free_hd[k] = free_hd[k+1];
    end
    free_cnt--;
  endfunction

  function automatic void used_drop(int idx);
    for (int k = idx; k + 1 < used_cnt; k++) begin
      used_sz[k] = used_sz[k+1];
      used_hd[k] = used_hd[k+1];
    end
    used_cnt--;
  endfunction

  // expected reply of one accepted beat; updates the mirrored tables
  function automatic pool_reply_t pool_outcome(logic [1:0] act, logic [SIZE_W-1:0] sz,
                                               logic [HANDLE_W-1:0] hd);
    pool_reply_t r;
    logic [63:0] ratio;
    logic [63:0] scaled;
    int imin, imax;
    bit hit;
    r = '0;
    imin = 0;
    imax = 0;
    hit = 0;
    ratio = (fit_ratio > RATIO_ONE) ? 64'd256 : 64'(fit_ratio);
    case (act)
      ACT_ALLOC: begin
        if (used_cnt >= TBL_DEPTH) begin
          r.status = STS_USED_FULL;
        end else begin
          for (int i = 0; i < free_cnt && !hit; i++) begin
            scaled = (64'(free_sz[i]) * ratio) >> 8;
            if (free_sz[i] >= sz && scaled <= 64'(sz)) begin
              r.out_handle = free_hd[i];
              r.out_size = free_sz[i];
              free_drop(i);
              used_sz[used_cnt] = r.out_size;
              used_hd[used_cnt] = r.out_handle;
              used_cnt++;
              hit = 1;
            end else begin
              if (free_sz[i] < free_sz[imin]) imin = i;
              if (free_sz[i] > free_sz[imax]) imax = i;
            end
          end
          if (hit) begin
            r.status = STS_REUSED;
          end else begin
            r.status = STS_NEED;
            // miss eviction: first smallest if all too small, first largest if all too big
            if (free_cnt > 0 && free_cnt >= int'(drop_thr)) begin
              if (free_sz[imax] < sz) begin
                r.evict_valid = 1'b1;
                r.evict_handle = free_hd[imin];
                free_drop(imin);
              end else if (free_sz[imin] > sz) begin
                r.evict_valid = 1'b1;
                r.evict_handle = free_hd[imax];
                free_drop(imax);
              end
            end
          end
        end
      end
      ACT_BIND: begin
        if (used_cnt >= TBL_DEPTH) begin
          r.status = STS_USED_FULL;
          r.evict_valid = 1'b1;
          r.evict_handle = hd;
        end else begin
          used_sz[used_cnt] = sz;
          used_hd[used_cnt] = hd;
          used_cnt++;
          r.status = STS_BOUND;
        end
      end
      default: begin
        r.status = STS_WILD;
        r.evict_valid = 1'b1;
        r.evict_handle = hd;
        for (int i = 0; i < used_cnt && !hit; i++) begin
          if (used_hd[i] == hd) begin
            scaled = 64'(used_sz[i]);
            used_drop(i);
            if (free_cnt >= TBL_DEPTH) begin
              r.status = STS_POOL_FULL;
            end else begin
              free_sz[free_cnt] = scaled[SIZE_W-1:0];
              free_hd[free_cnt] = hd;
              free_cnt++;
              r.status = STS_POOLED;
              r.evict_valid = 1'b0;
              r.evict_handle = '0;
            end
            hit = 1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // one beat on the input side; returns the predicted status
  task automatic send_beat(input logic [1:0] act, input logic [SIZE_W-1:0] sz,
                           input logic [HANDLE_W-1:0] hd, output logic [2:0] sts);
    int gap;
    pool_reply_t r;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, hd, sz, act};
    do @(posedge clk); while (!s_tready);
    sts = STS_WILD;
    if (act != ACT_NONE) begin
      r = pool_outcome(act, sz, hd);
      pending_replies = {pending_replies, r};
      sts = r.status;
    end
  endtask

  // input side quiet, every reply back, and the sequencer given time to settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[RATIO_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RATIO) fit_ratio = val[RATIO_W-1:0];
    else drop_thr = val[THR_W-1:0];
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return SIZE_W'($urandom_range(1, 40) * 64);
    endcase
  endfunction

  function automatic logic [HANDLE_W-1:0] fresh_handle();
    return HANDLE_W'({$urandom, $urandom});
  endfunction

  // output side: random stall per beat, or one long hold-off when asked
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // compare every reply beat with the oldest prediction
  always @(posedge clk) begin
    pool_reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[131:0];
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected reply beat %h", $time, got);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status != want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.out_handle != want.out_handle) begin
          $display("%0t out_handle exp %h got %h", $time, want.out_handle, got.out_handle);
          errors++;
        end
        if (got.out_size != want.out_size) begin
          $display("%0t out_size exp %h got %h", $time, want.out_size, got.out_size);
          errors++;
        end
        if (got.evict_valid != want.evict_valid) begin
          $display("%0t evict_valid exp %0d got %0d", $time, want.evict_valid,
                   got.evict_valid);
          errors++;
        end
        if (got.evict_handle != want.evict_handle) begin
          $display("%0t evict_handle exp %h got %h", $time, want.evict_handle,
                   got.evict_handle);
          errors++;
        end
      end
    end
  end

  // extremes, full in-use table, wild release, empty-pool miss, dropped action
  task automatic test_directed();
    logic [2:0] sts;
    send_beat(ACT_RELEASE, '1, '1, sts);          // wild, all ones
    send_beat(ACT_ALLOC, '0, '0, sts);            // miss on empty pool
    send_beat(ACT_NONE, '1, '1, sts);             // dropped
    for (int i = 0; i < TBL_DEPTH; i++)
      send_beat(ACT_BIND, (i == 0) ? '1 : SIZE_W'(i * 100), HANDLE_W'(i + 1) << 32, sts);
    send_beat(ACT_BIND, 32'd5, '0, sts);          // in-use table full
    send_beat(ACT_ALLOC, 32'd5, '1, sts);         // in-use full on allocate
    send_beat(ACT_RELEASE, 32'd0, HANDLE_W'(1) << 32, sts);
    send_beat(ACT_ALLOC, '1, '0, sts);            // exact reuse of the largest
  endtask

  // allocate/bind pairs with releases, lone binds and dropped actions mixed in; release-heavy drives the pool full
  task automatic test_random(int n, int release_pct);
    logic [2:0] sts;
    logic [SIZE_W-1:0] sz;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_beat(ACT_NONE, pick_size(), fresh_handle(), sts);
      end else if (r < 3 + release_pct) begin
        if (used_cnt > 0 && $urandom_range(0, 9) != 0)
          send_beat(ACT_RELEASE, pick_size(), used_hd[$urandom_range(0, used_cnt - 1)], sts);
        else
          send_beat(ACT_RELEASE, pick_size(), fresh_handle(), sts);
      end else if (r < 90) begin
        sz = pick_size();
        send_beat(ACT_ALLOC, sz, fresh_handle(), sts);
        if (sts == STS_NEED && $urandom_range(0, 4) != 0) begin
          k++;
          send_beat(ACT_BIND, ($urandom_range(0, 1) != 0) ? sz : pick_size(),
                    fresh_handle(), sts);
        end
      end else begin
        send_beat(ACT_BIND, pick_size(), fresh_handle(), sts);
      end
    end
  endtask

  // long output hold-off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    no_idle = 1;
    hold_cycles = 300;
    test_random(40, 30);
    no_idle = 0;
  endtask

  task automatic test_register_sweep();
    write_reg(CFG_RATIO, 256);
    write_reg(CFG_THRESH, 0);
    test_random(150, 30);
    write_reg(CFG_RATIO, 511);
    write_reg(CFG_THRESH, 31);
    test_random(150, 45);
    write_reg(CFG_RATIO, 192);
    write_reg(CFG_THRESH, 16);
    test_random(150, 40);
    write_reg(CFG_RATIO, 0);
    write_reg(CFG_THRESH, 4);
    no_idle = 1;
    test_random(150, 30);
    no_idle = 0;
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_RATIO, $urandom_range(0, 511));
      write_reg(CFG_THRESH, $urandom_range(0, 31));
      test_random(120, $urandom_range(25, 45));
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 0;
    hold_cycles = 0;
    free_cnt = 0;
    used_cnt = 0;
    fit_ratio = RATIO_RST;
    drop_thr = THR_RST;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RATIO;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(200, 30);       // reset register values
    test_backpressure();
    test_register_sweep();

    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
